[design/assert_macros.svh]
// Assertion macros shared by the liveness sweeper RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HBLS_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("liveness sweeper check failed");
`define HBLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("liveness sweeper check failed");
`define HBLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("liveness sweeper check failed");
`else
`define HBLS_ASSERT(lbl, clk, rst_n, cond)
`define HBLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HBLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/hbls_pkg.sv]
// Types and constants for the heartbeat liveness sweeper
`timescale 1ns / 1ps

package hbls_pkg;

    localparam int SOCKETS_DEF = 64;
    localparam int ID_W        = 6;
    localparam int REQ_W       = 3;
    localparam int TICK_W      = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd10;

    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_HB     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } st_t;

    // broadcast from the controller to every session cell
    typedef struct packed {
        logic clear;
        logic add;
        logic remove;
        logic hb;
        logic reload;
    } cell_cmd_t;

endpackage

[design/hbls_cell.sv]
// One session cell: member and awaiting bits plus the sweep token stage
`timescale 1ns / 1ps

module hbls_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  hbls_pkg::cell_cmd_t cmd,
    input  logic               sel,
    input  logic               token_in,
    output logic               token_out,
    output logic               drop
);

    logic member_reg;
    logic member_next;
    logic await_reg;
    logic await_next;
    logic token_reg;

    assign drop      = token_reg & member_reg & await_reg;
    assign token_out = token_reg;

    always_comb
    begin
        member_next = member_reg;
        await_next  = await_reg;
        if (cmd.clear)
        begin
            member_next = 1'b0;
            await_next  = 1'b0;
        end
        else if (cmd.reload)
        begin
            await_next = member_reg;
        end
        else if (sel && cmd.add)
        begin
            member_next = 1'b1;
        end
        else if (sel && cmd.remove)
        begin
            member_next = 1'b0;
            await_next  = 1'b0;
        end
        else if (sel && cmd.hb)
        begin
            await_next = 1'b0;
        end
        else if (drop)
        begin
            // drop the session as the token passes
            member_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= 1'b0;
            await_reg  <= 1'b0;
            token_reg  <= 1'b0;
        end
        else
        begin
            member_reg <= member_next;
            await_reg  <= await_next;
            token_reg  <= token_in;
        end
    end

endmodule

[design/hbls_ctrl.sv]
// Sweeper control: request decode, tick counter, sweep sequencing and result words
`timescale 1ns / 1ps

module hbls_ctrl #(
    parameter int SOCKETS = hbls_pkg::SOCKETS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hbls_pkg::REQ_W-1:0]  req_type,
    input  logic                        cfg_we,
    input  logic [hbls_pkg::TICK_W-1:0] cfg_wdata,
    input  logic                        drop_any,
    input  logic                        sweep_end,
    output logic                        busy,
    output logic                        launch,
    output hbls_pkg::cell_cmd_t         cmd,
    output logic                        result_valid,
    output logic [hbls_pkg::ID_W-1:0]   dropped_socket,
    output logic                        last
);

    localparam int IDX_W = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

    hbls_pkg::st_t state_reg;
    hbls_pkg::st_t state_next;

    logic [hbls_pkg::TICK_W-1:0] timeout_reg;
    logic [hbls_pkg::TICK_W-1:0] tick_reg;
    logic [hbls_pkg::TICK_W:0]   tick_inc;
    logic [IDX_W-1:0]            idx_reg;
    logic                        pend_valid_reg;
    logic [hbls_pkg::ID_W-1:0]   pend_id_reg;
    logic                        result_valid_reg;
    logic [hbls_pkg::ID_W-1:0]   dropped_reg;
    logic                        last_reg;
    logic                        accept;
    logic                        is_tick;

    assign tick_inc = {1'b0, tick_reg} + {{hbls_pkg::TICK_W{1'b0}}, 1'b1};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hbls_pkg::ST_IDLE:
            begin
                if (launch)
                    state_next = hbls_pkg::ST_SWEEP;
            end
            hbls_pkg::ST_SWEEP:
            begin
                if (sweep_end)
                    state_next = hbls_pkg::ST_FLUSH;
            end
            hbls_pkg::ST_FLUSH:
            begin
                state_next = hbls_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hbls_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy    = (state_reg != hbls_pkg::ST_IDLE);
        accept  = start & ~busy;
        is_tick = 1'b0;
        cmd     = '0;
        if (accept)
        begin
            unique case (req_type)
                hbls_pkg::REQ_TICK:   is_tick    = 1'b1;
                hbls_pkg::REQ_ADD:    cmd.add    = 1'b1;
                hbls_pkg::REQ_REMOVE: cmd.remove = 1'b1;
                hbls_pkg::REQ_HB:     cmd.hb     = 1'b1;
                hbls_pkg::REQ_CLEAR:  cmd.clear  = 1'b1;
                default:              cmd        = '0;
            endcase
        end
        cmd.reload = (state_reg == hbls_pkg::ST_FLUSH);
        launch     = is_tick && (tick_inc > {1'b0, timeout_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hbls_pkg::ST_IDLE;
            timeout_reg      <= hbls_pkg::TIMEOUT_RST;
            tick_reg         <= '0;
            idx_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b0;
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (is_tick)
                tick_reg <= launch ? '0 : tick_inc[hbls_pkg::TICK_W-1:0];
            if (launch)
                idx_reg <= '0;
            else if (state_reg == hbls_pkg::ST_SWEEP)
                idx_reg <= idx_reg + IDX_W'(1);
            // hold one found session back so the final word can carry last
            if (state_reg == hbls_pkg::ST_SWEEP && drop_any)
            begin
                pend_valid_reg   <= 1'b1;
                result_valid_reg <= pend_valid_reg;
            end
            else if (state_reg == hbls_pkg::ST_FLUSH)
            begin
                pend_valid_reg   <= 1'b0;
                result_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hbls_pkg::ST_SWEEP && drop_any)
        begin
            pend_id_reg <= hbls_pkg::ID_W'(idx_reg);
            dropped_reg <= pend_id_reg;
            last_reg    <= 1'b0;
        end
        else if (state_reg == hbls_pkg::ST_FLUSH)
        begin
            dropped_reg <= pend_id_reg;
            last_reg    <= 1'b1;
        end
    end

    assign result_valid   = result_valid_reg;
    assign dropped_socket = dropped_reg;
    assign last           = last_reg;

endmodule

[design/heartbeat_liveness_sweeper.sv]
// Top level of the heartbeat liveness sweeper
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Liveness monitor for SOCKETS sessions. A request word is taken when start is
// high and busy is low. Add, remove, heartbeat, clear and ticks that do not
// reach the timeout leave busy low. A tick that pushes the count past
// timeout_ticks starts a sweep: a token walks the chain of session cells, one
// cell per cycle, and busy is high through the sweep and the flush after it.
// Each dropped session is reported as one word on result_valid, lowest index
// first; the word for the final dropped session, marked by last, appears in
// the same cycle that busy falls. Results cannot be stalled: sample every
// cycle in which result_valid is high. The user must write timeout_ticks
// through cfg_we and cfg_wdata while the block is idle, which is not enforced.
module heartbeat_liveness_sweeper #(
    parameter int SOCKETS = hbls_pkg::SOCKETS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hbls_pkg::REQ_W-1:0]  req_type,
    input  logic [hbls_pkg::ID_W-1:0]   socket_id,
    input  logic                        cfg_we,
    input  logic [hbls_pkg::TICK_W-1:0] cfg_wdata,
    output logic                        result_valid,
    output logic [hbls_pkg::ID_W-1:0]   dropped_socket,
    output logic                        last
);

    hbls_pkg::cell_cmd_t cmd;
    logic                launch;
    logic [SOCKETS:0]    token;
    logic [SOCKETS-1:0]  drop;

    assign token[0] = launch;

    hbls_ctrl #(
        .SOCKETS (SOCKETS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .req_type       (req_type),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .drop_any       (|drop),
        .sweep_end      (token[SOCKETS]),
        .busy           (busy),
        .launch         (launch),
        .cmd            (cmd),
        .result_valid   (result_valid),
        .dropped_socket (dropped_socket),
        .last           (last)
    );

    for (genvar i = 0; i < SOCKETS; i++)
    begin : g_cell
        hbls_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (socket_id == hbls_pkg::ID_W'(i)),
            .token_in  (token[i]),
            .token_out (token[i+1]),
            .drop      (drop[i])
        );
    end

    `HBLS_ASSERT(a_single_token, clk, rst_n, $onehot0(token))
    `HBLS_ASSERT_IMP(a_one_drop, clk, rst_n, |drop, $onehot(drop))
    `HBLS_ASSERT_NEXT(a_launch_busy, clk, rst_n, launch, busy)
    `HBLS_ASSERT_IMP(a_last_after_sweep, clk, rst_n, result_valid && last, !busy)

endmodule
